### rtl/tad_pkg.sv
// Shared types and constants for the tenant activity decay table.
// Used by tad_div, tad_dpath, tad_ctrl and tenant_activity_decay_table.
package tad_pkg;

   localparam int KEY_W     = 64;
   localparam int COLOC_W   = 31;
   localparam int CNT_W31   = 31;
   localparam int TIME_W    = 63;
   localparam int PERIOD_W  = 37;
   localparam int LIMIT_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [TIME_W-1:0]  SCORE_MAX       = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0]  QUERY_SCORE     = 63'd1000000000;
   localparam logic [TIME_W-1:0]  SCORE_ADD_LIMIT = SCORE_MAX - QUERY_SCORE;
   localparam logic [CNT_W31-1:0] COUNT_MAX       = {CNT_W31{1'b1}};

   localparam logic [1:0] REQ_RECORD  = 2'd0;
   localparam logic [1:0] REQ_READOUT = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 37'd60000000;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd10;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [KEY_W-1:0]   tenant_key;
      logic [COLOC_W-1:0] colocation_id;
      logic [1:0]         cmd_kind;
      logic [TIME_W-1:0]  query_time;
      logic               all_rows;
   } req_type_type;

   typedef struct packed {
      logic [COLOC_W-1:0] row_colocation_id;
      logic [KEY_W-1:0]   row_tenant_key;
      logic [CNT_W31-1:0] reads_now;
      logic [CNT_W31-1:0] reads_prev;
      logic [31:0]        total_now;
      logic [31:0]        total_prev;
      logic [TIME_W-1:0]  row_score;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COLOC_W-1:0] coloc;
      logic [CNT_W31-1:0] rd_cur;
      logic [CNT_W31-1:0] wr_cur;
      logic [CNT_W31-1:0] rd_prev;
      logic [CNT_W31-1:0] wr_prev;
      logic [TIME_W-1:0]  last_seen;
      logic [TIME_W-1:0]  last_decay;
      logic [TIME_W-1:0]  score;
   } entry_type;

   typedef enum logic [1:0] {
      WSEL_WORK,
      WSEL_HOLD,
      WSEL_RDATA
   } wsel_type;

   typedef enum logic [1:0] {
      MODE_RECORD,
      MODE_EVICT,
      MODE_READ
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PDIV_GO,
      ST_PDIV_WAIT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_MISS,
      ST_NEW,
      ST_RF_RD,
      ST_RF_LD,
      ST_RF_ROLL,
      ST_RF_CHK,
      ST_RF_DIV,
      ST_RF_DEC,
      ST_RF_BUMP,
      ST_RF_WR,
      ST_SO_START,
      ST_SO_RD,
      ST_SO_LD,
      ST_SO_JCHK,
      ST_SO_CMP,
      ST_SO_DONE,
      ST_EM_RD,
      ST_EM_LD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic     req_load;
      logic     div_go;
      logic     div_age;     // 1: divide entry age, 0: divide query time
      logic     start_load;
      logic     work_load;
      logic     work_new;
      logic     work_roll;
      logic     work_decay;
      logic     work_bump;
      logic     hold_load;
      logic     rd_en;
      logic     wr_en;
      wsel_type wr_sel;
      logic     out_load;
      logic     out_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       all_rows;
      logic       coloc_ok;
      logic       match;
      logic       need_decay;
      logic       div_done;
      logic       out_free;
      logic       score_less;
   } status_type;

endpackage

### rtl/tenant_activity_decay_table.sv
// Top level of the tenant activity decay table: configuration registers and
// the controller / datapath pair. Depends on tad_pkg, tad_ctrl and tad_dpath.
//
// Keeps up to TABLE_DEPTH tenants (64-bit key plus colocation id) with read and
// write counts for this and the last period and a score that halves each
// elapsed period. One request word is handled at a time; req_stall stays high
// until it is done. Timing is set by the shared one-bit-per-cycle divider
// and the entry memory: a record first divides the query time to find the
// period boundary, searches the entries one by one and then updates the
// entry; when the table is full (3x limit) every entry is refreshed and
// insertion sorted first.
// A readout refreshes all N entries, sorts them, then emits the row words one
// at a time while rsp_stall is low; the last row has last_row set. A clear
// resets the entry count. Config writes are taken at any time and
// should only be made while idle.
module tenant_activity_decay_table #(
   parameter int TABLE_DEPTH = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tad_pkg::req_type_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tad_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [tad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tad_pkg::PERIOD_W-1:0]   csr_wr_data
);
   import tad_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_TOP = TABLE_DEPTH / 3;

   logic                track_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [PERIOD_W-1:0] period_eff;
   logic [CNT_W-1:0]    limit_eff;
   cmd_type             cmd;
   status_type          status;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff  <= 1'b1;
         period_ff <= PERIOD_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRACK:  track_ff  <= csr_wr_data[0];
            CSR_PERIOD: period_ff <= csr_wr_data;
            CSR_LIMIT:  limit_ff  <= csr_wr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero period behaves as one microsecond
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // limit clamped to 1 .. TABLE_DEPTH/3
   always_comb begin
      if (limit_ff == '0) limit_eff = CNT_W'(1);
      else if (32'(limit_ff) > LIM_TOP) limit_eff = CNT_W'(LIM_TOP);
      else limit_eff = CNT_W'(limit_ff);
   end

   tad_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .track_enable (track_ff),
      .limit        (limit_eff),
      .status       (status),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr)
   );

   tad_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .req_data  (req_data),
      .period    (period_eff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/tad_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tad_pkg for operand widths.
module tad_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [tad_pkg::TIME_W-1:0]    dividend,
   input  logic [tad_pkg::PERIOD_W-1:0]  divisor,
   output logic [tad_pkg::TIME_W-1:0]    quot,
   output logic [tad_pkg::PERIOD_W-1:0]  rem,
   output logic                          done
);
   import tad_pkg::*;

   localparam int STEP_W = $clog2(TIME_W);

   logic [TIME_W-1:0]   qd_ff, qd_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, qd_ff[TIME_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         qd_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(TIME_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[PERIOD_W]) begin
            rem_in = diff[PERIOD_W-1:0];
            qd_in  = {qd_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PERIOD_W-1:0];
            qd_in  = {qd_ff[TIME_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      qd_ff   <= qd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign quot = qd_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

### rtl/tad_dpath.sv
// Datapath: entry memory, working entry, sort holding entry, divider, result register.
// Depends on tad_pkg and tad_div.
module tad_dpath #(
   parameter int TABLE_DEPTH = 48,
   parameter int IDX_W       = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tad_pkg::cmd_type              cmd,
   output tad_pkg::status_type           status,
   input  logic [IDX_W-1:0]              rd_addr,
   input  logic [IDX_W-1:0]              wr_addr,
   input  tad_pkg::req_type_type         req_data,
   input  logic [tad_pkg::PERIOD_W-1:0]  period,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tad_pkg::rsp_type              rsp_data
);
   import tad_pkg::*;

   entry_type    mem [TABLE_DEPTH];
   entry_type    rd_data_ff;
   entry_type    work_ff, work_in;
   entry_type    hold_ff;
   entry_type    wr_data;
   req_type_type req_ff;
   logic [TIME_W-1:0] start_ff;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0]   div_dividend;
   logic [TIME_W-1:0]   div_quot;
   logic [PERIOD_W-1:0] div_rem;
   logic                div_done;

   logic [TIME_W-1:0]   age;
   logic [TIME_W-1:0]   gap;
   logic                rem_nz;
   logic [5:0]          shift_n;
   logic                decay_all;

   assign age          = start_ff - work_ff.last_decay;
   assign div_dividend = cmd.div_age ? age : req_ff.query_time;

   tad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (period),
      .quot     (div_quot),
      .rem      (div_rem),
      .done     (div_done)
   );

   // decay amount: ceil(age / period), all gone at 63 or more
   always_comb begin
      rem_nz    = (div_rem != '0);
      decay_all = (div_quot >= TIME_W'(63)) || ((div_quot == TIME_W'(62)) && rem_nz);
      shift_n   = div_quot[5:0] + {5'd0, rem_nz};
   end

   assign gap = start_ff - work_ff.last_seen;

   always_comb begin
      work_in = work_ff;
      if (cmd.work_load) begin
         work_in = rd_data_ff;
      end else if (cmd.work_new) begin
         work_in       = '0;
         work_in.key   = req_ff.tenant_key;
         work_in.coloc = req_ff.colocation_id;
      end else if (cmd.work_roll) begin
         if ((work_ff.last_seen < start_ff) &&
             ((work_ff.wr_cur != '0) || (work_ff.rd_cur != '0))) begin
            work_in.wr_prev = work_ff.wr_cur;
            work_in.wr_cur  = '0;
            work_in.rd_prev = work_ff.rd_cur;
            work_in.rd_cur  = '0;
         end
         if ((start_ff >= work_ff.last_seen) && (gap >= {{(TIME_W-PERIOD_W){1'b0}}, period})) begin
            work_in.wr_prev = '0;
            work_in.rd_prev = '0;
         end
         work_in.last_seen = req_ff.query_time;
      end else if (cmd.work_decay) begin
         work_in.score      = decay_all ? '0 : (work_ff.score >> shift_n);
         work_in.last_decay = req_ff.query_time;
      end else if (cmd.work_bump) begin
         work_in.score = (work_ff.score < SCORE_ADD_LIMIT) ?
                         (work_ff.score + QUERY_SCORE) : SCORE_MAX;
         if (req_ff.cmd_kind == KIND_READ) begin
            if (work_ff.rd_cur < COUNT_MAX) work_in.rd_cur = work_ff.rd_cur + 1'b1;
         end else if (req_ff.cmd_kind == KIND_WRITE) begin
            if (work_ff.wr_cur < COUNT_MAX) work_in.wr_cur = work_ff.wr_cur + 1'b1;
         end
      end
   end

   always_comb begin
      case (cmd.wr_sel)
         WSEL_WORK:  wr_data = work_ff;
         WSEL_HOLD:  wr_data = hold_ff;
         WSEL_RDATA: wr_data = rd_data_ff;
         default:    wr_data = work_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_in.row_colocation_id = rd_data_ff.coloc;
         rsp_in.row_tenant_key    = rd_data_ff.key;
         rsp_in.reads_now         = rd_data_ff.rd_cur;
         rsp_in.reads_prev        = rd_data_ff.rd_prev;
         rsp_in.total_now         = {1'b0, rd_data_ff.rd_cur} + {1'b0, rd_data_ff.wr_cur};
         rsp_in.total_prev        = {1'b0, rd_data_ff.rd_prev} + {1'b0, rd_data_ff.wr_prev};
         rsp_in.row_score         = rd_data_ff.score;
         rsp_in.last_row          = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      work_ff <= work_in;
      if (cmd.hold_load) hold_ff <= rd_data_ff;
      if (cmd.req_load) req_ff <= req_data;
      if (cmd.start_load) start_ff <= req_ff.query_time - {{(TIME_W-PERIOD_W){1'b0}}, div_rem};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.req_type   = req_ff.req_type;
      status.all_rows   = req_ff.all_rows;
      status.coloc_ok   = (req_ff.colocation_id != '0);
      status.match      = (rd_data_ff.key == req_ff.tenant_key) &&
                          (rd_data_ff.coloc == req_ff.colocation_id);
      status.need_decay = (start_ff > work_ff.last_decay);
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.score_less = (rd_data_ff.score < hold_ff.score);
   end

endmodule

### rtl/tad_ctrl.sv
// Sequencer for search, refresh, eviction, insertion sort and readout.
// Depends on tad_pkg; drives tad_dpath through cmd_type and reads status_type.
module tad_ctrl #(
   parameter int TABLE_DEPTH = 48,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 track_enable,
   input  logic [CNT_W-1:0]     limit,
   input  tad_pkg::status_type  status,
   output tad_pkg::cmd_type     cmd,
   output logic [IDX_W-1:0]     rd_addr,
   output logic [IDX_W-1:0]     wr_addr
);
   import tad_pkg::*;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rows_ff, rows_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] i_next;
   logic [CNT_W+1:0] limit3;
   logic [CNT_W-1:0] limit2;

   assign i_next = CNT_W'(i_ff) + 1'b1;
   assign limit3 = (CNT_W+2)'(limit) * 2'd3;
   assign limit2 = CNT_W'({limit, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_RECORD;
         count_ff <= '0;
         rows_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         rows_ff  <= rows_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      rows_in   = rows_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cmd       = '0;
      cmd.wr_sel = WSEL_WORK;
      rd_addr   = i_ff;
      wr_addr   = i_ff;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            unique case (status.req_type)
               REQ_RECORD: begin
                  if (track_enable && status.coloc_ok) begin
                     mode_in  = MODE_RECORD;
                     state_in = ST_PDIV_GO;
                  end
               end
               REQ_READOUT: begin
                  if (count_ff != '0) begin
                     mode_in  = MODE_READ;
                     state_in = ST_PDIV_GO;
                  end
               end
               REQ_CLEAR: count_in = '0;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PDIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_PDIV_WAIT;
         end
         ST_PDIV_WAIT: begin
            if (status.div_done) begin
               cmd.start_load = 1'b1;
               i_in = '0;
               if (mode_ff == MODE_READ) state_in = ST_RF_RD;
               else if (count_ff == '0) state_in = ST_MISS;
               else state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (status.match) state_in = ST_RF_RD;
            else if (i_next == count_ff) state_in = ST_MISS;
            else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_MISS: begin
            if ((CNT_W+2)'(count_ff) >= limit3) begin
               mode_in  = MODE_EVICT;
               i_in     = '0;
               state_in = ST_RF_RD;
            end else begin
               state_in = ST_NEW;
            end
         end
         ST_NEW: begin
            cmd.work_new = 1'b1;
            mode_in      = MODE_RECORD;
            i_in         = IDX_W'(count_ff);
            count_in     = count_ff + 1'b1;
            state_in     = ST_RF_ROLL;
         end
         ST_RF_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_RF_LD;
         end
         ST_RF_LD: begin
            cmd.work_load = 1'b1;
            state_in = (mode_ff == MODE_EVICT) ? ST_RF_CHK : ST_RF_ROLL;
         end
         ST_RF_ROLL: begin
            cmd.work_roll = 1'b1;
            state_in      = ST_RF_CHK;
         end
         ST_RF_CHK: begin
            if (status.need_decay) begin
               cmd.div_go  = 1'b1;
               cmd.div_age = 1'b1;
               state_in    = ST_RF_DIV;
            end else begin
               state_in = (mode_ff == MODE_RECORD) ? ST_RF_BUMP : ST_RF_WR;
            end
         end
         ST_RF_DIV: begin
            if (status.div_done) state_in = ST_RF_DEC;
         end
         ST_RF_DEC: begin
            cmd.work_decay = 1'b1;
            state_in = (mode_ff == MODE_RECORD) ? ST_RF_BUMP : ST_RF_WR;
         end
         ST_RF_BUMP: begin
            cmd.work_bump = 1'b1;
            state_in      = ST_RF_WR;
         end
         ST_RF_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_WORK;
            if (mode_ff == MODE_RECORD) state_in = ST_IDLE;
            else if (i_next < count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_RF_RD;
            end else begin
               state_in = ST_SO_START;
            end
         end
         ST_SO_START: begin
            if (count_ff <= CNT_W'(1)) state_in = ST_SO_DONE;
            else begin
               i_in     = IDX_W'(1);
               state_in = ST_SO_RD;
            end
         end
         ST_SO_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SO_LD;
         end
         ST_SO_LD: begin
            cmd.hold_load = 1'b1;
            j_in          = i_ff;
            state_in      = ST_SO_JCHK;
         end
         ST_SO_JCHK: begin
            if (j_ff == '0) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WSEL_HOLD;
               wr_addr    = j_ff;
               if (i_next < count_ff) begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SO_RD;
               end else begin
                  state_in = ST_SO_DONE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = j_ff - 1'b1;
               state_in  = ST_SO_CMP;
            end
         end
         ST_SO_CMP: begin
            cmd.wr_en = 1'b1;
            wr_addr   = j_ff;
            if (status.score_less) begin
               cmd.wr_sel = WSEL_RDATA;
               j_in       = j_ff - 1'b1;
               state_in   = ST_SO_JCHK;
            end else begin
               cmd.wr_sel = WSEL_HOLD;
               if (i_next < count_ff) begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SO_RD;
               end else begin
                  state_in = ST_SO_DONE;
               end
            end
         end
         ST_SO_DONE: begin
            i_in = '0;
            if (mode_ff == MODE_EVICT) begin
               count_in = limit2;
               state_in = ST_NEW;
            end else begin
               rows_in  = (!status.all_rows && (count_ff > limit)) ? limit : count_ff;
               state_in = ST_EM_RD;
            end
         end
         ST_EM_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (i_next == rows_ff);
               if (i_next == rows_ff) state_in = ST_IDLE;
               else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RF_WR) |-> (CNT_W'(i_ff) < count_ff))
      else $error("refresh writes outside the filled table");

   a_sort_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SO_CMP) |-> ((j_ff != '0) && (j_ff <= i_ff)))
      else $error("sort compare with bad inner index");

   a_emit_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EM_LD) |-> ((CNT_W'(i_ff) < rows_ff) && (rows_ff <= count_ff)))
      else $error("readout row beyond table");

endmodule

### sim/tad_checker.sv
// Checker for the tenant activity decay table: watches the request, response
// and register ports, predicts every row word and compares. Needs tad_pkg.
`timescale 1ns / 1ps

module tad_checker #(
   parameter int TABLE_DEPTH = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tad_pkg::req_type_type          req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tad_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [tad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tad_pkg::PERIOD_W-1:0]   csr_wr_data,
   output int                             fail_count,
   output int                             pending
);
   import tad_pkg::*;

   localparam longint unsigned BONUS = 64'd1000000000;
   localparam longint unsigned TOP63 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned TOP31 = 64'h7FFF_FFFF;

   // mirror of the tenant table
   longint unsigned t_key[TABLE_DEPTH], t_col[TABLE_DEPTH];
   longint unsigned t_rd[TABLE_DEPTH], t_wr[TABLE_DEPTH];
   longint unsigned t_rdp[TABLE_DEPTH], t_wrp[TABLE_DEPTH];
   longint unsigned t_seen[TABLE_DEPTH], t_dec[TABLE_DEPTH], t_score[TABLE_DEPTH];
   int unsigned     n_tenants;
   longint unsigned cfg_track, cfg_period, cfg_limit;

   rsp_type         row_q[$];

   function automatic longint unsigned period_len();
      return (cfg_period == 0) ? 64'd1 : cfg_period;
   endfunction

   function automatic int unsigned row_limit();
      if (cfg_limit < 1) return 1;
      if (cfg_limit > TABLE_DEPTH / 3) return TABLE_DEPTH / 3;
      return int'(cfg_limit);
   endfunction

   function automatic void roll_counts(int i, longint unsigned now);
      longint unsigned p, st;
      p  = period_len();
      st = now - now % p;
      if (t_seen[i] < st && (t_wr[i] != 0 || t_rd[i] != 0)) begin
         t_wrp[i] = t_wr[i];
         t_wr[i]  = 0;
         t_rdp[i] = t_rd[i];
         t_rd[i]  = 0;
      end
      if (st >= t_seen[i] && st - t_seen[i] >= p) begin
         t_wrp[i] = 0;
         t_rdp[i] = 0;
      end
      t_seen[i] = now;
   endfunction

   function automatic void age_score(int i, longint unsigned now);
      longint unsigned p, st, n;
      p  = period_len();
      st = now - now % p;
      if (st <= t_dec[i]) return;
      n = (st - t_dec[i] + p - 1) / p;
      t_score[i] = (n >= 63) ? 64'd0 : (t_score[i] >> n);
      t_dec[i] = now;
   endfunction

   function automatic void swap_tenants(int a, int b);
      longint unsigned t;
      t = t_key[a];   t_key[a] = t_key[b];     t_key[b] = t;
      t = t_col[a];   t_col[a] = t_col[b];     t_col[b] = t;
      t = t_rd[a];    t_rd[a] = t_rd[b];       t_rd[b] = t;
      t = t_wr[a];    t_wr[a] = t_wr[b];       t_wr[b] = t;
      t = t_rdp[a];   t_rdp[a] = t_rdp[b];     t_rdp[b] = t;
      t = t_wrp[a];   t_wrp[a] = t_wrp[b];     t_wrp[b] = t;
      t = t_seen[a];  t_seen[a] = t_seen[b];   t_seen[b] = t;
      t = t_dec[a];   t_dec[a] = t_dec[b];     t_dec[b] = t;
      t = t_score[a]; t_score[a] = t_score[b]; t_score[b] = t;
   endfunction

   // stable insertion sort, highest score first
   function automatic void rank_tenants();
      int j;
      for (int i = 1; i < n_tenants && i < TABLE_DEPTH; i++) begin
         j = i;
         while (j > 0 && t_score[j-1] < t_score[j]) begin
            swap_tenants(j - 1, j);
            j--;
         end
      end
   endfunction

   function automatic void note_query(req_type_type w);
      int i;
      int unsigned lim;
      longint unsigned now;
      lim = row_limit();
      now = 64'(w.query_time);
      for (i = 0; i < n_tenants; i++)
         if (t_key[i] == w.tenant_key && t_col[i] == 64'(w.colocation_id)) break;
      if (i >= n_tenants) begin
         if (n_tenants >= 3 * lim) begin
            for (int k = 0; k < n_tenants; k++) age_score(k, now);
            rank_tenants();
            n_tenants = 2 * lim;
         end
         i = n_tenants;
         if (i >= TABLE_DEPTH) return;
         t_key[i] = w.tenant_key;
         t_col[i] = 64'(w.colocation_id);
         t_rd[i] = 0; t_wr[i] = 0; t_rdp[i] = 0; t_wrp[i] = 0;
         t_seen[i] = 0; t_dec[i] = 0; t_score[i] = 0;
         n_tenants++;
      end
      roll_counts(i, now);
      age_score(i, now);
      t_score[i] = (t_score[i] < TOP63 - BONUS) ? t_score[i] + BONUS : TOP63;
      if (w.cmd_kind == KIND_READ) begin
         if (t_rd[i] < TOP31) t_rd[i]++;
      end else if (w.cmd_kind == KIND_WRITE) begin
         if (t_wr[i] < TOP31) t_wr[i]++;
      end
   endfunction

   function automatic void predict_rows(req_type_type w);
      int unsigned n;
      rsp_type r;
      longint unsigned now;
      now = 64'(w.query_time);
      for (int i = 0; i < n_tenants; i++) begin
         roll_counts(i, now);
         age_score(i, now);
      end
      rank_tenants();
      n = n_tenants;
      if (!w.all_rows && n > row_limit()) n = row_limit();
      for (int i = 0; i < n; i++) begin
         r.row_colocation_id = t_col[i][COLOC_W-1:0];
         r.row_tenant_key    = t_key[i];
         r.reads_now         = t_rd[i][CNT_W31-1:0];
         r.reads_prev        = t_rdp[i][CNT_W31-1:0];
         r.total_now         = 32'(t_rd[i] + t_wr[i]);
         r.total_prev        = 32'(t_rdp[i] + t_wrp[i]);
         r.row_score         = t_score[i][TIME_W-1:0];
         r.last_row          = (i + 1 == n);
         row_q.push_back(r);
      end
   endfunction

   function automatic bit field_ok(string f, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, f, e, a);
         return 0;
      end
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      bit ok;
      if (reset) begin
         n_tenants  = 0;
         cfg_track  = 1;
         cfg_period = 64'(PERIOD_RESET);
         cfg_limit  = 64'(LIMIT_RESET);
         row_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRACK:  cfg_track  = 64'(csr_wr_data[0]);
               CSR_PERIOD: cfg_period = 64'(csr_wr_data);
               CSR_LIMIT:  cfg_limit  = 64'(csr_wr_data[LIMIT_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (row_q.size() == 0) begin
               $display("%0t ns: unexpected row word, expected none, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               e  = row_q.pop_front();
               ok = 1;
               ok &= field_ok("row_colocation_id", 64'(e.row_colocation_id),
                              64'(rsp_data.row_colocation_id));
               ok &= field_ok("row_tenant_key", e.row_tenant_key, rsp_data.row_tenant_key);
               ok &= field_ok("reads_now", 64'(e.reads_now), 64'(rsp_data.reads_now));
               ok &= field_ok("reads_prev", 64'(e.reads_prev), 64'(rsp_data.reads_prev));
               ok &= field_ok("total_now", 64'(e.total_now), 64'(rsp_data.total_now));
               ok &= field_ok("total_prev", 64'(e.total_prev), 64'(rsp_data.total_prev));
               ok &= field_ok("row_score", 64'(e.row_score), 64'(rsp_data.row_score));
               ok &= field_ok("last_row", 64'(e.last_row), 64'(rsp_data.last_row));
               if (!ok) fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.req_type)
               REQ_RECORD:
                  if (cfg_track != 0 && req_data.colocation_id != 0) note_query(req_data);
               REQ_CLEAR:   n_tenants = 0;
               REQ_READOUT: predict_rows(req_data);
               default: ;
            endcase
         end
      end
      pending = row_q.size();
   end

   final if (row_q.size() != 0)
      $display("%0t ns: %0d row words never arrived", $time, row_q.size());

endmodule

### sim/testbench.sv
// Top of the tenant activity decay table testbench: clock, reset, register
// setup, request stimulus, response back-pressure and verdict. Needs tad_pkg,
// tad_checker and the tenant_activity_decay_table RTL.
`timescale 1ns / 1ps

module testbench;
   import tad_pkg::*;

   localparam int  DEPTH      = 48;
   localparam int  SETTLE     = 12000;    // worst case eviction pass, with margin
   localparam int  CYCLE_MAX  = 4000000;
   localparam int  HOLD_LEN   = 4000;     // the one long receiver hold-off

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [PERIOD_W-1:0]   csr_wr_data;

   int                    fail_count;
   int                    pending;
   int                    cycles;
   bit                    held_once;

   longint unsigned       now_us;      // running query time
   longint unsigned       cur_period;
   longint unsigned       key_pool[24];
   int                    burst_left;

   tenant_activity_decay_table #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wr_data
   );

   tad_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wr_data,
      .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stall modes re-picked periodically from the cycle counter, plus one long
   // hold-off once rows are flowing so the block backs up into its input
   initial begin
      int mode;
      rsp_stall = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (cycles % 64 == 0) mode = $urandom_range(0, 3);
         if (!held_once && rsp_valid && cycles > 20000) begin
            held_once = 1;
            rsp_stall = 1;
            repeat (HOLD_LEN) @(negedge clock);
         end
         case (mode)
            0: rsp_stall = 0;
            1: rsp_stall = ($urandom_range(0, 1) == 0);
            2: rsp_stall = ($urandom_range(0, 9) != 0);
            default: rsp_stall = ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic reg_write(logic [CSR_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
      @(negedge clock);
      csr_wr_en   = 1;
      csr_index   = idx;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 0;
      if (idx == CSR_PERIOD) cur_period = (val == 0) ? 1 : 64'(val);
   endtask

   // offer one word and hold it until taken; most bursts end with a random gap
   task automatic send_word(req_type_type w);
      bit busy;
      @(negedge clock);
      req_valid = 1;
      req_data  = w;
      #1;
      forever begin
         busy = req_stall;
         @(posedge clock);
         if (!busy) break;
         @(negedge clock);
         #1;
      end
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 8);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_valid = 0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   endtask

   function automatic req_type_type make_word(logic [1:0] rt, longint unsigned k,
                                              logic [COLOC_W-1:0] c, logic [1:0] kind,
                                              longint unsigned t, bit all);
      req_type_type w;
      w.req_type      = rt;
      w.tenant_key    = k;
      w.colocation_id = c;
      w.cmd_kind      = kind;
      w.query_time    = t[TIME_W-1:0];
      w.all_rows      = all;
      return w;
   endfunction

   // move the clock of the traffic along: mostly small steps, sometimes whole
   // periods, a big jump, or a step back in time
   task automatic advance_time();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: now_us += $urandom_range(0, 1000) * (cur_period / 4000 + 1);
         5, 6:          now_us += cur_period * $urandom_range(1, 3);
         7:             now_us += cur_period * $urandom_range(4, 70);
         8:             now_us -= (now_us > cur_period) ? cur_period / 2 : 0;
         default: ;
      endcase
      now_us &= 64'h7FFF_FFFF_FFFF_FFFF;
   endtask

   task automatic random_word();
      int pick;
      longint unsigned k;
      logic [COLOC_W-1:0] c;
      pick = $urandom_range(0, 99);
      advance_time();
      if ($urandom_range(0, 2) == 0) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(0, 23)];
      c = ($urandom_range(0, 3) == 0) ? COLOC_W'($urandom) : COLOC_W'($urandom_range(1, 3));
      if (pick < 4) c = 0;
      if (pick < 78)
         send_word(make_word(REQ_RECORD, k, c, 2'($urandom_range(0, 3)), now_us, 0));
      else if (pick < 92)
         send_word(make_word(REQ_READOUT, k, c, 2'($urandom), now_us, $urandom_range(0, 1)));
      else if (pick < 96)
         send_word(make_word(REQ_CLEAR, k, c, 2'($urandom), now_us, $urandom_range(0, 1)));
      else
         send_word(make_word(2'd3, k, c, 2'($urandom), now_us, $urandom_range(0, 1)));
   endtask

   // drain: nothing outstanding, then let a last record or eviction finish
   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic phase(bit trk, longint unsigned per, int lim, int count);
      reg_write(CSR_TRACK, PERIOD_W'(trk));
      reg_write(CSR_PERIOD, PERIOD_W'(per));
      reg_write(CSR_LIMIT, PERIOD_W'(lim));
      repeat (count) random_word();
      send_word(make_word(REQ_READOUT, 0, 0, 0, now_us, 1));
      settle();
   endtask

   initial begin
      req_valid   = 0;
      req_data    = '0;
      csr_wr_en   = 0;
      csr_index   = CSR_TRACK;
      csr_wr_data = '0;
      cycles      = 0;
      held_once   = 0;
      burst_left  = 0;
      cur_period  = 64'(PERIOD_RESET);
      now_us      = 64'd5000000;
      reset       = 1;
      for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = 64'd0;
      key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, field extremes, every request and command kind
      reg_write(CSR_TRACK, 1);
      reg_write(CSR_PERIOD, 37'd60000000);
      reg_write(CSR_LIMIT, 10);
      send_word(make_word(REQ_READOUT, 0, 0, 0, 0, 1));             // empty table
      send_word(make_word(REQ_RECORD, 0, 1, KIND_READ, 0, 0));
      send_word(make_word(REQ_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, {COLOC_W{1'b1}},
                          KIND_WRITE, 1000, 0));
      send_word(make_word(REQ_RECORD, 0, 1, 2'd2, 2000, 0));         // score only
      send_word(make_word(REQ_RECORD, 0, 1, 2'd3, 3000, 0));
      send_word(make_word(REQ_RECORD, 64'd5, 0, KIND_READ, 3000, 0)); // bad colocation
      send_word(make_word(2'd3, 64'd5, 7, KIND_READ, 3000, 1));       // unknown request
      send_word(make_word(REQ_RECORD, 0, 2, KIND_READ, 61000000, 0)); // same key, new group
      send_word(make_word(REQ_RECORD, 0, 1, KIND_READ, 125000000, 0));// period rollover
      send_word(make_word(REQ_READOUT, 0, 0, 0, 130000000, 0));
      send_word(make_word(REQ_RECORD, 0, 1, KIND_WRITE, 400000000, 0));// long gap, prev cleared
      send_word(make_word(REQ_RECORD, 0, 1, KIND_READ, 100, 0));       // time goes backwards
      send_word(make_word(REQ_READOUT, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1)); // decay to zero
      send_word(make_word(REQ_RECORD, 64'd9, 3, KIND_READ, 64'h7FFF_FFFF_FFFF_FFFF, 0));
      send_word(make_word(REQ_READOUT, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0));
      send_word(make_word(REQ_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, {COLOC_W{1'b1}}, 2'd3,
                          64'h7FFF_FFFF_FFFF_FFFF, 1));
      send_word(make_word(REQ_READOUT, 0, 0, 0, 0, 1));
      settle();

      // tracking off: records ignored, readout still works
      reg_write(CSR_TRACK, 0);
      send_word(make_word(REQ_RECORD, 64'd3, 3, KIND_READ, 10, 0));
      send_word(make_word(REQ_READOUT, 0, 0, 0, 20, 1));
      settle();

      now_us = 64'd1000;
      phase(1, 64'd1000000, 1, 18);                       // 1 s period, limit 1
      phase(1, 64'd86400000000, 16, 26);                  // one-day period, full table
      phase(1, 64'd0, 0, 14);                             // zero period, limit clamped up
      phase(1, 64'h1F_FFFF_FFFF, 31, 18);                 // wide period, limit clamped down
      phase(1, 64'd60000000, 4, 18);
      phase(0, 64'd7, 10, 6);

      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### tenant_activity_decay_table.f
rtl/tad_pkg.sv
rtl/tad_div.sv
rtl/tad_dpath.sv
rtl/tad_ctrl.sv
rtl/tenant_activity_decay_table.sv
sim/tad_checker.sv
sim/testbench.sv
